FILE: rtl/bounded_top_k_smallest_tracker_core_assert.svh
// Assertion macros for the bounded top-k smallest tracker.
`ifndef BOUNDED_TOP_K_SMALLEST_TRACKER_CORE_ASSERT_SVH
`define BOUNDED_TOP_K_SMALLEST_TRACKER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BTK_ASSERT_SAME(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BTK_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BTK_ASSERT_SAME(label, clock, reset, ante, cons)
`define BTK_ASSERT_NEXT(label, clock, reset, ante, cons)
`endif
`endif

FILE: rtl/btk_pkg.sv
// Shared types and constants for the bounded top-k smallest tracker.
package btk_pkg;

  localparam int Capacity = 64;
  localparam int ValueW   = 32;
  localparam int CountW   = 7;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdQuery  = 1'b1;

  typedef logic signed [ValueW-1:0] value_t;

  typedef struct packed {
    logic   insert;
    logic   rotate;
    value_t ins_value;
  } cell_ctrl_t;

endpackage

FILE: rtl/btk_if.sv
// Valid/ready channel interfaces for commands and results.
interface btk_req_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  btk_pkg::value_t              value;
  logic [btk_pkg::CountW-1:0]   count;

  modport source (output valid, cmd, value, count, input ready);
  modport sink   (input valid, cmd, value, count, output ready);
endinterface

interface btk_rsp_if;
  logic            valid;
  logic            ready;
  btk_pkg::value_t result_value;
  logic            last;
  logic            empty_res;
  logic            clamped;

  modport source (output valid, result_value, last, empty_res, clamped, input ready);
  modport sink   (input valid, result_value, last, empty_res, clamped, output ready);
endinterface

FILE: rtl/bounded_top_k_smallest_tracker_core.sv
// Top level of the bounded top-k smallest tracker.
// Holds up to CAPACITY signed values, sorted ascending in a chain of cells.
// An insert is accepted back to back while no query runs and the output
// register is free. A query with a nonzero result count, once taken, holds
// off the input while the occupied cells rotate as a ring by one place per
// step, for one full turn, the head cell feeding the output register for the
// first count steps, so the store is back in order when the query ends; a
// stalled output holds the rotation while results are still due. A zero or
// empty query returns its single result without a rotation. No command is taken while a query runs.
`include "bounded_top_k_smallest_tracker_core_assert.svh"
module bounded_top_k_smallest_tracker_core #(
  parameter int CAPACITY = btk_pkg::Capacity
) (
  input  logic           clk,
  input  logic           rst,
  btk_req_if.sink        req,
  btk_rsp_if.source      rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic StIdle  = 1'b0;
  localparam logic StQuery = 1'b1;

  logic                       state;
  logic [CW-1:0]              fill;
  logic [CW-1:0]              step;
  logic [CW-1:0]              n_q;
  logic                       clamp_q;

  logic                       out_free;
  logic                       acc;
  logic                       is_insert;
  logic                       is_query;
  logic                       full;
  logic                       clamp;
  logic [CW-1:0]              n_sel;
  logic [CW-1:0]              last_idx;
  logic                       emit;
  logic                       rotate;

  btk_pkg::cell_ctrl_t        ctrl;
  btk_pkg::value_t            cell_v [CAPACITY];
  logic                       cell_lt [CAPACITY];

  assign out_free  = !rsp.valid || rsp.ready;
  assign req.ready = (state == StIdle) && out_free;
  assign acc       = req.valid && req.ready;
  assign is_insert = acc && (req.cmd == btk_pkg::CmdInsert);
  assign is_query  = acc && (req.cmd == btk_pkg::CmdQuery);
  assign full      = fill == CW'(CAPACITY);
  assign clamp     = req.count > btk_pkg::CountW'(fill);
  assign n_sel     = clamp ? fill : CW'(req.count);
  assign last_idx  = fill - CW'(1);
  assign emit      = step < n_q;
  assign rotate    = (state == StQuery) && (!emit || out_free);

  assign ctrl.insert    = is_insert;
  assign ctrl.rotate    = rotate;
  assign ctrl.ins_value = req.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    btk_pkg::value_t prev_v;
    btk_pkg::value_t next_v;
    logic            prev_lt;

    if (i == 0) begin : g_first
      assign prev_v  = cell_v[0];
      assign prev_lt = 1'b0;
    end else begin : g_mid
      assign prev_v  = cell_v[i-1];
      assign prev_lt = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_v = cell_v[0];
    end else begin : g_body
      assign next_v = cell_v[i+1];
    end

    btk_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (CW'(i) < fill),
      .wrap       (last_idx == CW'(i)),
      .prev_lt    (prev_lt),
      .prev_value (prev_v),
      .next_value (next_v),
      .head_value (cell_v[0]),
      .value      (cell_v[i]),
      .lt         (cell_lt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      fill  <= '0;
      step  <= '0;
    end else begin
      if (is_insert && !full) begin
        fill <= fill + CW'(1);
      end
      if (is_query && (n_sel != '0)) begin
        state <= StQuery;
        step  <= '0;
      end
      if (rotate) begin
        step <= step + CW'(1);
        if (step == last_idx) begin
          state <= StIdle;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_query) begin
      n_q     <= n_sel;
      clamp_q <= clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((is_query && (n_sel == '0)) || (rotate && emit)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_query && (n_sel == '0)) begin
      rsp.result_value <= '0;
      rsp.last         <= 1'b1;
      rsp.empty_res    <= 1'b1;
      rsp.clamped      <= clamp;
    end else if (rotate && emit) begin
      rsp.result_value <= cell_v[0];
      rsp.last         <= step == (n_q - CW'(1));
      rsp.empty_res    <= 1'b0;
      rsp.clamped      <= clamp_q;
    end
  end

  `BTK_ASSERT_SAME(a_fill_bound, clk, rst, 1'b1, fill <= CW'(CAPACITY))
  `BTK_ASSERT_SAME(a_busy_blocks, clk, rst, state == StQuery, !req.ready)
  `BTK_ASSERT_NEXT(a_fill_grows, clk, rst, is_insert && !full, fill == $past(fill) + CW'(1))
  `BTK_ASSERT_SAME(a_empty_last, clk, rst, rsp.valid && rsp.empty_res, rsp.last)

endmodule

FILE: rtl/btk_cell.sv
// One cell of the sorted value chain: sorted insert and ring rotation.
module btk_cell (
  input  logic                clk,
  input  btk_pkg::cell_ctrl_t ctrl,
  input  logic                valid,
  input  logic                wrap,
  input  logic                prev_lt,
  input  btk_pkg::value_t     prev_value,
  input  btk_pkg::value_t     next_value,
  input  btk_pkg::value_t     head_value,
  output btk_pkg::value_t     value,
  output logic                lt
);

  assign lt = !valid || (ctrl.ins_value < value);

  always_ff @(posedge clk) begin
    if (ctrl.insert && lt) begin
      value <= prev_lt ? prev_value : ctrl.ins_value;
    end else if (ctrl.rotate) begin
      value <= wrap ? head_value : next_value;
    end
  end

endmodule
